[hdl/haversine_distance_unit_assert.svh]
// Assertion macros used by the port checker of the haversine distance unit.
`ifndef HAVERSINE_DISTANCE_UNIT_ASSERT_SVH
`define HAVERSINE_DISTANCE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define HDU_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("haversine distance unit: port check failed");

// A consequence that must hold in the same cycle as its antecedent.
`define HDU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("haversine distance unit: port check failed");

`endif

[hdl/hdu_pkg.sv]
// Types, constants and helper functions of the haversine distance unit.
package hdu_pkg;

   // Angle scaling of the coordinate ports; the reduction below relies on it.
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int ANG_G           = ANGLE_FRAC_BITS + 1;

   localparam int LAT_W    = 24;
   localparam int LON_W    = 25;
   localparam int RADIUS_W = 23;
   localparam int DIST_W   = 25;

   localparam int AW     = 27;
   localparam int MAG_W  = ANG_G + 7;
   localparam int K_W    = 27;
   localparam int PROD_W = MAG_W + K_W;
   localparam int CW     = 34;
   localparam int FRAC   = 30;
   localparam int SQ_W   = FRAC + 1;
   localparam int REM_W  = 2 * SQ_W;
   localparam int TH_W   = CW - 1;
   localparam int DP_W   = RADIUS_W + TH_W;

   // Cycles of the pipeline outside the two CORDIC sections.
   localparam int LAT_FIXED = 9 + SQ_W;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

   typedef logic signed [AW-1:0]     ang_type;
   typedef logic signed [CW-1:0]     cw_type;
   typedef logic signed [2*CW-1:0]   cwp_type;

   localparam ang_type U90  = AW'(90 * (2 ** ANG_G));
   localparam ang_type U180 = AW'(180 * (2 ** ANG_G));
   localparam ang_type U360 = AW'(360 * (2 ** ANG_G));

   // pi/180 scaled by 2^32, with pi taken as 3.14159.
   localparam logic [63:0] K64 = ((64'd314159 << 32) + 64'd9000000) / 64'd18000000;
   localparam logic [K_W-1:0] DEG_TO_RAD_K = K64[K_W-1:0];

   localparam cw_type INV_GAIN = 34'sh026DD3B6A;
   localparam cw_type ONE_Q30  = 34'sh040000000;

   localparam cw_type ATAN_Q30 [32] = '{
      34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
      34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
      34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
      34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
      34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
      34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002,
      34'sh00000001, 34'sh00000000
   };

   // Rounds a product of two Q2.30 values back to Q2.30.
   function automatic cw_type mul_round(input cwp_type p);
      cwp_type sum;
      sum = p + (cwp_type'(1) <<< (FRAC - 1));
      return cw_type'(sum >>> FRAC);
   endfunction

endpackage

[hdl/hdu_rot_cordic.sv]
// Rotation-mode CORDIC pipeline giving sine and cosine of a Q2.30 angle.
module hdu_rot_cordic #(
   parameter int STAGES = 24
) (
   input  logic            clock,
   input  hdu_pkg::cw_type ang,
   input  logic            flip,
   output hdu_pkg::cw_type sin_val,
   output hdu_pkg::cw_type cos_val
);

   hdu_pkg::cw_type x_ff [STAGES];
   hdu_pkg::cw_type y_ff [STAGES];
   hdu_pkg::cw_type z_ff [STAGES];
   logic            flip_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      hdu_pkg::cw_type xp, yp, zp;
      hdu_pkg::cw_type x_in, y_in, z_in;
      logic            fp;

      if (s == 0) begin : g_first
         assign xp = hdu_pkg::INV_GAIN;
         assign yp = '0;
         assign zp = ang;
         assign fp = flip;
      end else begin : g_next
         assign xp = x_ff[s-1];
         assign yp = y_ff[s-1];
         assign zp = z_ff[s-1];
         assign fp = flip_ff[s-1];
      end

      always_comb begin
         if (zp >= 0) begin
            x_in = xp - (yp >>> s);
            y_in = yp + (xp >>> s);
            z_in = zp - hdu_pkg::ATAN_Q30[s];
         end else begin
            x_in = xp + (yp >>> s);
            y_in = yp - (xp >>> s);
            z_in = zp + hdu_pkg::ATAN_Q30[s];
         end
      end

      always_ff @(posedge clock) begin
         x_ff[s]    <= x_in;
         y_ff[s]    <= y_in;
         z_ff[s]    <= z_in;
         flip_ff[s] <= fp;
      end
   end

   // An angle folded in from beyond a right angle keeps its sine but negates its cosine.
   assign sin_val = y_ff[STAGES-1];
   assign cos_val = flip_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];

endmodule

[hdl/hdu_isqrt.sv]
// Pipelined digit-by-digit square root of a Q2.30 value, one result bit per stage.
module hdu_isqrt (
   input  logic                     clock,
   input  logic [hdu_pkg::SQ_W-1:0] val,
   output logic [hdu_pkg::SQ_W-1:0] root
);

   localparam int SW = hdu_pkg::SQ_W;
   localparam int RW = hdu_pkg::REM_W;

   logic [RW-1:0] rem_ff  [SW];
   logic [SW-1:0] root_ff [SW];

   for (genvar j = 0; j < SW; j++) begin : g_step
      localparam int B = SW - 1 - j;
      logic [RW-1:0] rp, trial, rem_in;
      logic [SW-1:0] qp, root_in;

      if (j == 0) begin : g_first
         assign rp = RW'(val) << hdu_pkg::FRAC;
         assign qp = '0;
      end else begin : g_next
         assign rp = rem_ff[j-1];
         assign qp = root_ff[j-1];
      end

      // Setting bit B adds (2*root + 2^B) * 2^B to the square.
      assign trial = (RW'(qp) << (B + 1)) | (RW'(1) << (2 * B));

      always_comb begin
         if (rp >= trial) begin
            rem_in  = rp - trial;
            root_in = qp | (SW'(1) << B);
         end else begin
            rem_in  = rp;
            root_in = qp;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
      end
   end

   assign root = root_ff[SW-1];

endmodule

[hdl/haversine_distance_unit.sv]
// Throughput: one coordinate pair per cycle; every stage, including both CORDIC sections
// and the 31-step square root, is fully pipelined, and busy is low whenever out of reset.
// Reset clears every valid bit and loads the earth radius register with 6371000.
// Results leave on rsp_strobe for one cycle; the receiver cannot stall them.
module haversine_distance_unit #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [hdu_pkg::LAT_W-1:0]    req_lat_a,
   input  logic signed [hdu_pkg::LON_W-1:0]    req_lon_a,
   input  logic signed [hdu_pkg::LAT_W-1:0]    req_lat_b,
   input  logic signed [hdu_pkg::LON_W-1:0]    req_lon_b,
   output logic                                rsp_strobe,
   output logic        [hdu_pkg::DIST_W-1:0]   rsp_distance_m,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [hdu_pkg::RADIUS_W-1:0] csr_earth_radius_m
);

   localparam int AW  = hdu_pkg::AW;
   localparam int LAT = 2 * CORDIC_STAGES + hdu_pkg::LAT_FIXED;

   logic [hdu_pkg::RADIUS_W-1:0] radius_ff;
   logic [LAT-1:0]               vld_ff;

   assign busy      = reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= hdu_pkg::RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_earth_radius_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start && !busy};
      end
   end

   // Lanes: half latitude difference, half longitude difference, latitude a, latitude b,
   // all in units of 2^-(ANGLE_FRAC_BITS+1) degree.
   hdu_pkg::ang_type ang_in [4];
   hdu_pkg::ang_type ang_ff [4];

   assign ang_in[0] = AW'(req_lat_b) - AW'(req_lat_a);
   assign ang_in[1] = AW'(req_lon_b) - AW'(req_lon_a);
   assign ang_in[2] = AW'(req_lat_a) <<< 1;
   assign ang_in[3] = AW'(req_lat_b) <<< 1;

   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         ang_ff[l] <= ang_in[l];
      end
   end

   // Reduce into (-180,180] and fold into [-90,90].
   hdu_pkg::ang_type            red_v  [4];
   hdu_pkg::ang_type            fold_v [4];
   logic                        flip_in [4];
   logic                        neg_in  [4];
   logic [hdu_pkg::MAG_W-1:0]   mag_in  [4];
   logic                        flip1_ff [4];
   logic                        neg1_ff  [4];
   logic [hdu_pkg::MAG_W-1:0]   mag_ff   [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (ang_ff[l] > hdu_pkg::U180) begin
            red_v[l] = ang_ff[l] - hdu_pkg::U360;
         end else if (ang_ff[l] <= -hdu_pkg::U180) begin
            red_v[l] = ang_ff[l] + hdu_pkg::U360;
         end else begin
            red_v[l] = ang_ff[l];
         end
         if (red_v[l] > hdu_pkg::U90) begin
            fold_v[l]  = hdu_pkg::U180 - red_v[l];
            flip_in[l] = 1'b1;
         end else if (red_v[l] < -hdu_pkg::U90) begin
            fold_v[l]  = -hdu_pkg::U180 - red_v[l];
            flip_in[l] = 1'b1;
         end else begin
            fold_v[l]  = red_v[l];
            flip_in[l] = 1'b0;
         end
         neg_in[l] = fold_v[l] < 0;
         mag_in[l] = hdu_pkg::MAG_W'(neg_in[l] ? -fold_v[l] : fold_v[l]);
      end
   end

   logic [hdu_pkg::PROD_W-1:0] prod_ff  [4];
   logic                       flip2_ff [4];
   logic                       neg2_ff  [4];
   logic [hdu_pkg::PROD_W-1:0] rsum_v   [4];
   hdu_pkg::cw_type            zmag_v   [4];
   hdu_pkg::cw_type            zang_in  [4];
   hdu_pkg::cw_type            zang_ff  [4];
   logic                       flip3_ff [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         rsum_v[l]  = prod_ff[l] + (hdu_pkg::PROD_W'(1) << (hdu_pkg::ANG_G + 1));
         zmag_v[l]  = hdu_pkg::CW'(rsum_v[l] >> (hdu_pkg::ANG_G + 2));
         zang_in[l] = neg2_ff[l] ? -zmag_v[l] : zmag_v[l];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         flip1_ff[l] <= flip_in[l];
         neg1_ff[l]  <= neg_in[l];
         mag_ff[l]   <= mag_in[l];
         prod_ff[l]  <= hdu_pkg::PROD_W'(mag_ff[l]) *
                        hdu_pkg::PROD_W'(hdu_pkg::DEG_TO_RAD_K);
         flip2_ff[l] <= flip1_ff[l];
         neg2_ff[l]  <= neg1_ff[l];
         zang_ff[l]  <= zang_in[l];
         flip3_ff[l] <= flip2_ff[l];
      end
   end

   hdu_pkg::cw_type sin_w [4];
   hdu_pkg::cw_type cos_w [4];

   for (genvar l = 0; l < 4; l++) begin : g_lane
      hdu_rot_cordic #(
         .STAGES (CORDIC_STAGES)
      ) u_rot (
         .clock   (clock),
         .ang     (zang_ff[l]),
         .flip    (flip3_ff[l]),
         .sin_val (sin_w[l]),
         .cos_val (cos_w[l])
      );
   end

   // The term a = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2).
   hdu_pkg::cwp_type pcc_ff, psl_ff, pso_ff, pt_ff;
   hdu_pkg::cw_type  sl2_ff;
   logic signed [hdu_pkg::CW:0]  asum_v;
   logic [hdu_pkg::SQ_W-1:0]     a_in, b_in, a_ff, b_ff;

   always_comb begin
      asum_v = (hdu_pkg::CW + 1)'(sl2_ff) + (hdu_pkg::CW + 1)'(hdu_pkg::mul_round(pt_ff));
      if (asum_v < 0) begin
         a_in = '0;
      end else if (asum_v > (hdu_pkg::CW + 1)'(hdu_pkg::ONE_Q30)) begin
         a_in = hdu_pkg::SQ_W'(1) << hdu_pkg::FRAC;
      end else begin
         a_in = hdu_pkg::SQ_W'(asum_v);
      end
      b_in = (hdu_pkg::SQ_W'(1) << hdu_pkg::FRAC) - a_in;
   end

   always_ff @(posedge clock) begin
      pcc_ff <= hdu_pkg::cwp_type'(cos_w[2]) * hdu_pkg::cwp_type'(cos_w[3]);
      psl_ff <= hdu_pkg::cwp_type'(sin_w[0]) * hdu_pkg::cwp_type'(sin_w[0]);
      pso_ff <= hdu_pkg::cwp_type'(sin_w[1]) * hdu_pkg::cwp_type'(sin_w[1]);
      sl2_ff <= hdu_pkg::mul_round(psl_ff);
      pt_ff  <= hdu_pkg::cwp_type'(hdu_pkg::mul_round(pcc_ff)) *
                hdu_pkg::cwp_type'(hdu_pkg::mul_round(pso_ff));
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   logic [hdu_pkg::SQ_W-1:0] sa_w, sb_w;

   hdu_isqrt u_sqrt_a (
      .clock (clock),
      .val   (a_ff),
      .root  (sa_w)
   );

   hdu_isqrt u_sqrt_b (
      .clock (clock),
      .val   (b_ff),
      .root  (sb_w)
   );

   // Vectoring CORDIC for the angle of (sqrt(1-a), sqrt(a)).
   hdu_pkg::cw_type vx_ff [CORDIC_STAGES];
   hdu_pkg::cw_type vy_ff [CORDIC_STAGES];
   hdu_pkg::cw_type vz_ff [CORDIC_STAGES];

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
      hdu_pkg::cw_type xp, yp, zp, x_in, y_in, z_in;

      if (s == 0) begin : g_first
         assign xp = hdu_pkg::cw_type'(sb_w);
         assign yp = hdu_pkg::cw_type'(sa_w);
         assign zp = '0;
      end else begin : g_next
         assign xp = vx_ff[s-1];
         assign yp = vy_ff[s-1];
         assign zp = vz_ff[s-1];
      end

      always_comb begin
         if (yp >= 0) begin
            x_in = xp + (yp >>> s);
            y_in = yp - (xp >>> s);
            z_in = zp + hdu_pkg::ATAN_Q30[s];
         end else begin
            x_in = xp - (yp >>> s);
            y_in = yp + (xp >>> s);
            z_in = zp - hdu_pkg::ATAN_Q30[s];
         end
      end

      always_ff @(posedge clock) begin
         vx_ff[s] <= x_in;
         vy_ff[s] <= y_in;
         vz_ff[s] <= z_in;
      end
   end

   // A last-stage undershoot below zero counts as a zero angle.
   hdu_pkg::cw_type            vz_last;
   logic [hdu_pkg::TH_W-1:0]   theta_v;
   logic [hdu_pkg::DP_W-1:0]   dprod_ff;
   logic [hdu_pkg::DP_W-1:0]   dsum_v;
   logic [hdu_pkg::DIST_W-1:0] dist_ff;

   assign vz_last = vz_ff[CORDIC_STAGES-1];
   assign theta_v = (vz_last < 0) ? '0 : {vz_last[hdu_pkg::TH_W-2:0], 1'b0};
   assign dsum_v  = dprod_ff + (hdu_pkg::DP_W'(1) << (hdu_pkg::FRAC - 1));

   always_ff @(posedge clock) begin
      dprod_ff <= hdu_pkg::DP_W'(radius_ff) * hdu_pkg::DP_W'(theta_v);
      dist_ff  <= hdu_pkg::DIST_W'(dsum_v >> hdu_pkg::FRAC);
   end

   assign rsp_strobe     = vld_ff[LAT-1];
   assign rsp_distance_m = dist_ff;

endmodule

[hdl/hdu_port_checker.sv]
// Port-level checker of the haversine distance unit and its bind to the top level.
`include "haversine_distance_unit_assert.svh"

module hdu_port_checker #(
   parameter int LATENCY = 88
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic csr_valid,
   input logic csr_ready
);

   localparam int CNT_W = $clog2(LATENCY + 1);

   logic [CNT_W-1:0] since_reset_ff;
   logic             armed;

   // Counts edges out of reset, so that a full request window is known to be reset-free.
   always_ff @(posedge clock) begin
      if (reset) begin
         since_reset_ff <= '0;
      end else if (since_reset_ff != CNT_W'(LATENCY)) begin
         since_reset_ff <= since_reset_ff + 1'b1;
      end
   end

   assign armed = since_reset_ff == CNT_W'(LATENCY);

   `HDU_ASSERT(a_never_busy, clock, reset, !busy)
   `HDU_ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_strobe, $past(start && !busy, LATENCY))
   `HDU_ASSERT_IMPL(a_req_gives_rsp, clock, reset, armed && $past(start && !busy, LATENCY), rsp_strobe)
   `HDU_ASSERT_IMPL(a_csr_taken, clock, reset, csr_valid, csr_ready)

endmodule

bind haversine_distance_unit hdu_port_checker #(
   .LATENCY (2 * CORDIC_STAGES + hdu_pkg::LAT_FIXED)
) u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
